// ===== hw/rtl/uvsq_pkg.sv =====
// shared types, constants and tables of the uv sphere quad vertex generator
package uvsq_pkg;

  localparam int unsigned MaxDivisionsDef = 256;
  localparam int unsigned AngleBitsDef    = 16;
  localparam int unsigned CordicStepsDef  = 16;

  // divider remainder width: denominators reach twice a 9-bit count
  localparam int unsigned DenW = 10;
  // cordic datapath widths, x/y in Q1.30 with headroom, z in turn units
  localparam int unsigned CorXW = 34;
  localparam int unsigned CorZW = 33;
  localparam logic signed [CorXW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [16:0] PosLimit = 17'sd65535;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_SLICES = 2'd1,
    REG_STACKS = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_e;

  // per-vertex info that travels beside the datapath
  typedef struct packed {
    logic [2:0]  corner;
    logic        bad;
    logic        last;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } vtx_sb_t;

  // arctangent of 2^-i in 32-bit turn units
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    unique case (i)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // quad corner (0..3) used by each of the six vertices
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    unique case (k)
      3'd0: c = 2'd0;
      3'd1: c = 2'd1;
      3'd2: c = 2'd2;
      3'd3: c = 2'd0;
      3'd4: c = 2'd2;
      3'd5: c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/uvsq_div_cell.sv =====
// one restoring division step: one quotient bit per cell
module uvsq_div_cell #(
  parameter int unsigned QW = 17,
  parameter int unsigned DW = 10
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [QW-1:0] quo_i,
  input  logic [DW-1:0] den_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] num_o,
  output logic [QW-1:0] quo_o,
  output logic [DW-1:0] den_o
);
  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // bring down the next numerator bit and try a subtract
  always_comb begin
    trial = {rem_i, num_i[QW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_o <= {num_i[QW-2:0], 1'b0};
      quo_o <= {quo_i[QW-2:0], ge};
      den_o <= den_i;
    end
  end
endmodule

// ===== hw/rtl/uvsq_cordic_cell.sv =====
// one rotation-mode cordic iteration with its registers
module uvsq_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [uvsq_pkg::CorXW-1:0] x_i,
  input  logic signed [uvsq_pkg::CorXW-1:0] y_i,
  input  logic signed [uvsq_pkg::CorZW-1:0] z_i,
  input  logic                           fold_i,
  output logic signed [uvsq_pkg::CorXW-1:0] x_o,
  output logic signed [uvsq_pkg::CorXW-1:0] y_o,
  output logic signed [uvsq_pkg::CorZW-1:0] z_o,
  output logic                           fold_o
);
  import uvsq_pkg::*;

  localparam logic signed [CorZW-1:0] Atan = CorZW'(atan_turn(STEP));

  logic signed [CorXW-1:0] dx;
  logic signed [CorXW-1:0] dy;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!z_i[CorZW-1]) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - Atan;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + Atan;
      end
      fold_o <= fold_i;
    end
  end
endmodule

// ===== hw/rtl/uv_sphere_quad_vertices.sv =====
// top level of the uv sphere quad vertex generator
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: stack_number[7:0], slice_number[15:8]
// m_*       out  m_tvalid/m_tready  tdata: vertex, tlast: final_vertex, tuser: out_of_range
// cfg_*     in   cfg_we             cfg_idx, cfg_data
//
// a new quad can be taken as the last ends; one vertex issues per cycle unless stalled
// a vertex passes the issue registers, QW divider cells, CORDIC_STEPS cordic cells,
// the product and scale registers before m_*; QW = max(ANGLE_BITS,16)+1 divider cells
// the whole pipeline holds while a result waits on m_tready; no clearing after reset
module uv_sphere_quad_vertices #(
  parameter int unsigned MAX_DIVISIONS = uvsq_pkg::MaxDivisionsDef,
  parameter int unsigned ANGLE_BITS    = uvsq_pkg::AngleBitsDef,
  parameter int unsigned CORDIC_STEPS  = uvsq_pkg::CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // stack_number, slice_number
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [87:0] m_tdata_o,   // corner, pos_x, pos_y, pos_z, tex_u, tex_v
  output logic        m_tlast_o,   // final_vertex
  output logic        m_tuser_o,   // out_of_range
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import uvsq_pkg::*;

  localparam int unsigned QW = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 1;
  localparam int unsigned DW = DenW;
  localparam int unsigned NW = QW + DW;
  localparam int unsigned D  = QW;
  localparam int unsigned S  = CORDIC_STEPS;
  localparam int unsigned P  = D + S + 3;
  localparam logic [8:0] MaxDiv = (MAX_DIVISIONS > 511) ? 9'd511 : 9'(MAX_DIVISIONS);
  localparam logic signed [63:0] HalfQ30 = 64'sd536870912;
  localparam logic signed [49:0] HalfQ30W = 50'sd536870912;

  // configuration registers
  logic [15:0] radius_q;
  logic [8:0]  slices_q;
  logic [8:0]  stacks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      slices_q <= 9'd32;
      stacks_q <= 9'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RADIUS: radius_q <= cfg_data_i;
        REG_SLICES: slices_q <= cfg_data_i[8:0];
        REG_STACKS: stacks_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [P-1:0] vld_q;
  assign en = !vld_q[P-1] || m_tready_i;

  // quad sequencer: six vertices per quad
  logic       busy_q;
  logic [2:0] k_q;
  logic [7:0] stk_q;
  logic [7:0] slc_q;
  logic       issue;
  logic       accept;

  assign s_tready_o = en && (!busy_q || (k_q == 3'd5));
  assign accept     = s_tvalid_i && s_tready_o;
  assign issue      = busy_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= 3'd0;
    end else if (accept) begin
      busy_q <= 1'b1;
      k_q    <= 3'd0;
    end else if (issue) begin
      if (k_q == 3'd5) begin
        busy_q <= 1'b0;
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stk_q <= s_tdata_i[7:0];
      slc_q <= s_tdata_i[15:8];
    end
  end

  // vertex indexes, counts and divider operands
  logic [1:0]    corner;
  logic [8:0]    ti;
  logic [8:0]    pi;
  logic [8:0]    ns;
  logic [8:0]    nk;
  logic          bad;
  logic [NW-1:0] num_c [4];
  logic [DW-1:0] den_c [4];

  always_comb begin
    corner = corner_of(k_q);
    ti = {1'b0, slc_q} + ((corner == 2'd1 || corner == 2'd2) ? 9'd1 : 9'd0);
    pi = {1'b0, stk_q} + ((corner == 2'd2 || corner == 2'd3) ? 9'd1 : 9'd0);
    ns = (slices_q > MaxDiv) ? MaxDiv : slices_q;
    nk = (stacks_q > MaxDiv) ? MaxDiv : stacks_q;
    bad = !(({1'b0, stk_q} < nk) && ({1'b0, slc_q} < ns));
    num_c[0] = (NW'(ti) << ANGLE_BITS) + NW'(ns >> 1);
    den_c[0] = DW'(ns);
    num_c[1] = (NW'(pi) << ANGLE_BITS) + NW'(nk);
    den_c[1] = DW'({nk, 1'b0});
    num_c[2] = (NW'(ti) << 16) + NW'(ns >> 1);
    den_c[2] = DW'(ns);
    num_c[3] = (NW'(pi) << 16) + NW'(nk >> 1);
    den_c[3] = DW'(nk);
  end

  // issue stage registers
  vtx_sb_t       sb_q  [P];
  logic [DW-1:0] rem0_q [4];
  logic [QW-1:0] num0_q [4];
  logic [DW-1:0] den0_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[P-2:0], issue};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        rem0_q[l] <= num_c[l][NW-1:QW];
        num0_q[l] <= num_c[l][QW-1:0];
        den0_q[l] <= den_c[l];
      end
    end
  end

  // divider chains: angle t, angle p, tex u, tex v
  logic [DW-1:0] rem_w [4][D+1];
  logic [QW-1:0] num_w [4][D+1];
  logic [QW-1:0] quo_w [4][D+1];
  logic [DW-1:0] den_w [4][D+1];

  for (genvar l = 0; l < 4; l++) begin : g_div_lane
    assign rem_w[l][0] = rem0_q[l];
    assign num_w[l][0] = num0_q[l];
    assign quo_w[l][0] = '0;
    assign den_w[l][0] = den0_q[l];
    for (genvar d = 0; d < D; d++) begin : g_div_cell
      uvsq_div_cell #(.QW(QW), .DW(DW)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .rem_i (rem_w[l][d]),
        .num_i (num_w[l][d]),
        .quo_i (quo_w[l][d]),
        .den_i (den_w[l][d]),
        .rem_o (rem_w[l][d+1]),
        .num_o (num_w[l][d+1]),
        .quo_o (quo_w[l][d+1]),
        .den_o (den_w[l][d+1])
      );
    end
  end

  // sideband travels beside the datapath; tex picked up after the divider
  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= {k_q, bad, (k_q == 3'd5), 17'd0, 17'd0};
      for (int j = 1; j < P; j++) begin
        if (j == D + 1) begin
          sb_q[j] <= {sb_q[j-1].corner, sb_q[j-1].bad, sb_q[j-1].last,
                      quo_w[2][D][16:0], quo_w[3][D][16:0]};
        end else begin
          sb_q[j] <= sb_q[j-1];
        end
      end
    end
  end

  // turn angle, wrapped, folded about the half turn
  logic signed [CorXW-1:0] x_w [2][S+1];
  logic signed [CorXW-1:0] y_w [2][S+1];
  logic signed [CorZW-1:0] z_w [2][S+1];
  logic                    f_w [2][S+1];

  for (genvar l = 0; l < 2; l++) begin : g_cor_lane
    logic [31:0] ang;
    assign ang = 32'(quo_w[l][D][ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    assign f_w[l][0] = ang[31] ^ ang[30];
    assign z_w[l][0] = CorZW'($signed({ang[30], ang[30:0]}));
    assign x_w[l][0] = GainQ30;
    assign y_w[l][0] = '0;
    for (genvar c = 0; c < S; c++) begin : g_cor_cell
      uvsq_cordic_cell #(.STEP(c)) u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .x_i    (x_w[l][c]),
        .y_i    (y_w[l][c]),
        .z_i    (z_w[l][c]),
        .fold_i (f_w[l][c]),
        .x_o    (x_w[l][c+1]),
        .y_o    (y_w[l][c+1]),
        .z_o    (z_w[l][c+1]),
        .fold_o (f_w[l][c+1])
      );
    end
  end

  // unit vector products in Q1.30
  logic signed [31:0] ct;
  logic signed [31:0] st;
  logic signed [31:0] cp;
  logic signed [31:0] sp;
  logic signed [63:0] cs_p;
  logic signed [63:0] ss_p;
  logic signed [63:0] cs_r;
  logic signed [63:0] ss_r;
  logic signed [31:0] cs_q;
  logic signed [31:0] ss_q;
  logic signed [31:0] ncp_q;

  always_comb begin
    ct = f_w[0][S] ? -x_w[0][S][31:0] : x_w[0][S][31:0];
    st = f_w[0][S] ? -y_w[0][S][31:0] : y_w[0][S][31:0];
    cp = f_w[1][S] ? -x_w[1][S][31:0] : x_w[1][S][31:0];
    sp = f_w[1][S] ? -y_w[1][S][31:0] : y_w[1][S][31:0];
    cs_p = ct * sp;
    ss_p = st * sp;
    cs_r = (cs_p + HalfQ30) >>> 30;
    ss_r = (ss_p + HalfQ30) >>> 30;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_q  <= cs_r[31:0];
      ss_q  <= ss_r[31:0];
      ncp_q <= -cp;
    end
  end

  // scale by radius, round and saturate to Q8.8
  function automatic logic signed [16:0] scale_pos(input logic signed [32:0] u,
                                                   input logic [15:0] r);
    logic signed [49:0] p;
    logic signed [49:0] v;
    p = u * $signed({1'b0, r});
    v = (p + HalfQ30W) >>> 30;
    if (v > 50'(PosLimit)) begin
      return PosLimit;
    end else if (v < -50'(PosLimit)) begin
      return -PosLimit;
    end
    return v[16:0];
  endfunction

  logic signed [16:0] px_q;
  logic signed [16:0] py_q;
  logic signed [16:0] pz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= scale_pos(-(33'(cs_q)), radius_q);
      py_q <= scale_pos(33'(ncp_q), radius_q);
      pz_q <= scale_pos(33'(ss_q), radius_q);
    end
  end

  // output item; out of range vertices carry zeros
  vtx_sb_t ob;
  assign ob = sb_q[P-1];
  assign m_tvalid_o = vld_q[P-1];
  assign m_tlast_o  = ob.last;
  assign m_tuser_o  = ob.bad;
  assign m_tdata_o  = ob.bad ? {85'd0, ob.corner}
                             : {ob.tex_v, ob.tex_u, pz_q, py_q, px_q, ob.corner};
endmodule

// ===== hw/rtl/uvsq_checker.sv =====
// port-level checks of the uv sphere quad vertex generator, bound to the top
module uvsq_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [87:0] m_tdata_o,
  input logic        m_tlast_o,
  input logic        m_tuser_o
);
  // a stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("output item changed while stalled");

  // last marks the sixth vertex only
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tlast_o == (m_tdata_o[2:0] == 3'd5)))
    else $error("final vertex flag does not match corner");

  // out of range vertices carry zero payload
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> (m_tdata_o[87:3] == 85'd0))
    else $error("out of range vertex has nonzero payload");

  // corners step in order within a quad
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && !m_tlast_o |=>
      !m_tvalid_o || (m_tdata_o[2:0] == $past(m_tdata_o[2:0]) + 3'd1))
    else $error("corner out of order");
endmodule

bind uv_sphere_quad_vertices uvsq_assert u_uvsq_assert (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tlast_o  (m_tlast_o),
  .m_tuser_o  (m_tuser_o)
);
